// ----- hdl/assert_macros.svh -----
// assertion macros for the dispatcher checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/dbpd_pkg.sv -----
package dbpd_pkg;

    localparam int ID_W      = 6;
    localparam int IN_TIME_W = 32;
    localparam int NUM_Q     = 4;

    // queue numbering: {direction, low class}
    localparam logic [1:0] Q_EH = 2'd0;
    localparam logic [1:0] Q_EL = 2'd1;
    localparam logic [1:0] Q_WH = 2'd2;
    localparam logic [1:0] Q_WL = 2'd3;

    localparam logic [1:0] STREAK_MAX = 2'd3;

    localparam logic [1:0] STREAK_LIMIT_RST = 2'd2;
    localparam logic       FIRST_DIR_RST    = 1'b1;

    typedef enum logic {
        REG_STREAK_LIMIT = 1'b0,
        REG_FIRST_DIR    = 1'b1
    } t_reg_idx;

    typedef enum logic {
        REQ_ARRIVE = 1'b0,
        REQ_FINISH = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_DROPPED     = 2'd1,
        ST_IDLE_FINISH = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_GRANT = 1'b1
    } t_state;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctrl;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_queue_stat;

endpackage

// ----- hdl/dbpd_req_if.sv -----
interface dbpd_req_if import dbpd_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [ID_W-1:0]      train_id;
    logic                 train_dir;
    logic                 hi_class;
    logic [IN_TIME_W-1:0] ready_time;

    modport source (
        output valid, req_type, train_id, train_dir, hi_class, ready_time,
        input  ready
    );
    modport sink (
        input  valid, req_type, train_id, train_dir, hi_class, ready_time,
        output ready
    );
endinterface

// ----- hdl/dbpd_grant_if.sv -----
interface dbpd_grant_if import dbpd_pkg::*;;
    logic            valid;
    logic            ready;
    logic            grant_valid;
    logic [ID_W-1:0] grant_id;
    logic            grant_dir;
    logic [1:0]      status;

    modport source (
        output valid, grant_valid, grant_id, grant_dir, status,
        input  ready
    );
    modport sink (
        input  valid, grant_valid, grant_id, grant_dir, status,
        output ready
    );
endinterface

// ----- hdl/dbpd_cell.sv -----
module dbpd_cell import dbpd_pkg::*; #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                  i_clk,
    input  t_cell_ctrl            i_ctrl,
    input  logic                  i_valid,
    input  logic [ID_W-1:0]       i_new_id,
    input  logic [TIME_WIDTH-1:0] i_new_time,
    input  logic                  i_prev_before,
    input  logic [ID_W-1:0]       i_prev_id,
    input  logic [TIME_WIDTH-1:0] i_prev_time,
    input  logic [ID_W-1:0]       i_next_id,
    input  logic [TIME_WIDTH-1:0] i_next_time,
    output logic                  o_before,
    output logic [ID_W-1:0]       o_id,
    output logic [TIME_WIDTH-1:0] o_time
);

    logic [ID_W-1:0]       r_id;
    logic [TIME_WIDTH-1:0] r_time;
    logic [ID_W-1:0]       n_id;
    logic [TIME_WIDTH-1:0] n_time;

    // new entry sorts ahead of this one (equal entries keep arrival order)
    assign o_before = !i_valid || (i_new_time < r_time) ||
                      ((i_new_time == r_time) && (i_new_id < r_id));

    always_comb begin
        n_id   = r_id;
        n_time = r_time;
        if (i_ctrl.ins) begin
            if (i_prev_before) begin
                n_id   = i_prev_id;
                n_time = i_prev_time;
            end else if (o_before) begin
                n_id   = i_new_id;
                n_time = i_new_time;
            end
        end else if (i_ctrl.pop) begin
            n_id   = i_next_id;
            n_time = i_next_time;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_time <= n_time;
    end

    assign o_id   = r_id;
    assign o_time = r_time;

endmodule

// ----- hdl/dbpd_queue.sv -----
module dbpd_queue import dbpd_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctrl            i_ctrl,
    input  logic [ID_W-1:0]       i_new_id,
    input  logic [TIME_WIDTH-1:0] i_new_time,
    output t_queue_stat           o_stat,
    output logic [ID_W-1:0]       o_head_id,
    output logic [TIME_WIDTH-1:0] o_head_time
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    logic                  w_before [QUEUE_DEPTH];
    logic [ID_W-1:0]       w_id     [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0] w_time   [QUEUE_DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic                  w_prev_before;
            logic [ID_W-1:0]       w_prev_id;
            logic [TIME_WIDTH-1:0] w_prev_time;
            logic [ID_W-1:0]       w_next_id;
            logic [TIME_WIDTH-1:0] w_next_time;

            if (gi == 0) begin : g_first
                assign w_prev_before = 1'b0;
                assign w_prev_id     = '0;
                assign w_prev_time   = '0;
            end else begin : g_mid
                assign w_prev_before = w_before[gi-1];
                assign w_prev_id     = w_id[gi-1];
                assign w_prev_time   = w_time[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_last
                assign w_next_id   = '0;
                assign w_next_time = '0;
            end else begin : g_inner
                assign w_next_id   = w_id[gi+1];
                assign w_next_time = w_time[gi+1];
            end

            dbpd_cell #(
                .TIME_WIDTH(TIME_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (i_ctrl),
                .i_valid      (r_count > CW'(gi)),
                .i_new_id     (i_new_id),
                .i_new_time   (i_new_time),
                .i_prev_before(w_prev_before),
                .i_prev_id    (w_prev_id),
                .i_prev_time  (w_prev_time),
                .i_next_id    (w_next_id),
                .i_next_time  (w_next_time),
                .o_before     (w_before[gi]),
                .o_id         (w_id[gi]),
                .o_time       (w_time[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (i_ctrl.ins) begin
            n_count = r_count + CW'(1);
        end else if (i_ctrl.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_stat.full     = (r_count == CW'(QUEUE_DEPTH));
    assign o_stat.nonempty = (r_count != '0);
    assign o_head_id       = w_id[0];
    assign o_head_time     = w_time[0];

endmodule

// ----- hdl/direction_balanced_priority_dispatcher.sv -----
// direction balanced priority dispatcher
// i_req (sink): one transaction is an event, either an arrival (req_type 0) that
//   queues a requester by direction and class, or a finish (req_type 1) that
//   frees the shared resource
// o_grant (source): exactly one transaction per event, carrying whether a
//   requester was granted, its id and direction, and the event status
// apb port: streak_limit at address 0, first_direction at address 4; write only
//   while no event is in flight
// each queue is a chain of sorted cells; an arrival is inserted by every cell
//   comparing itself with the new entry and shifting right
// each event has an update cycle, in which it is accepted, then a grant cycle that
//   reads the four queue heads, pops the winner and registers the result; the next
//   event is taken only once the grant cycle is done
// a stalled receiver holds the result in the output register; a new event is
//   still taken, and its grant cycle waits until the output register frees
// reset: all queues empty, resource free, streak and history cleared,
//   streak_limit 2, first_direction west; no clearing pass is needed
module direction_balanced_priority_dispatcher import dbpd_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    dbpd_req_if.sink     i_req,
    dbpd_grant_if.source o_grant
);

    localparam int TW_IN = (TIME_WIDTH < IN_TIME_W) ? TIME_WIDTH : IN_TIME_W;

    // configuration registers
    logic [1:0] r_streak_limit;
    logic       r_first_dir;

    // control state
    t_state     r_state,    n_state;
    logic       r_busy,     n_busy;
    logic       r_gdir,     n_gdir;
    logic [1:0] r_streak,   n_streak;
    logic       r_last,     n_last;
    logic       r_ever,     n_ever;
    logic       r_out_valid, n_out_valid;

    // payload
    t_status         r_status,      n_status;
    logic            r_grant_valid, n_grant_valid;
    logic [ID_W-1:0] r_grant_id,    n_grant_id;
    logic            r_grant_dir,   n_grant_dir;
    t_status         r_out_status,  n_out_status;

    // queue side
    t_cell_ctrl            w_ctrl      [NUM_Q];
    t_queue_stat           w_stat      [NUM_Q];
    logic [ID_W-1:0]       w_head_id   [NUM_Q];
    logic [TIME_WIDTH-1:0] w_head_time [NUM_Q];
    logic [NUM_Q-1:0]      w_ne;
    logic [1:0]            w_q_in;
    logic [TIME_WIDTH-1:0] w_new_time;

    // grant selection
    logic       w_first_any, w_opp_any, w_opp;
    logic [1:0] w_first_q, w_opp_q, w_hi_q, w_lo_q, w_g_q;
    logic       w_hi_e_first, w_lo_e_first;
    logic       w_g_valid;

    // apb: always ready, write in the access phase
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FIRST_DIR) ? {31'd0, r_first_dir}
                                                : {30'd0, r_streak_limit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_streak_limit <= STREAK_LIMIT_RST;
            r_first_dir    <= FIRST_DIR_RST;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_FIRST_DIR) begin
                r_first_dir <= pwdata[0];
            end else begin
                r_streak_limit <= pwdata[1:0];
            end
        end
    end

    // four sorted queues
    assign w_q_in     = {i_req.train_dir, ~i_req.hi_class};
    assign w_new_time = TIME_WIDTH'(i_req.ready_time[TW_IN-1:0]);

    genvar gq;
    generate
        for (gq = 0; gq < NUM_Q; gq++) begin : g_queue
            dbpd_queue #(
                .QUEUE_DEPTH(QUEUE_DEPTH),
                .TIME_WIDTH (TIME_WIDTH)
            ) u_queue (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (w_ctrl[gq]),
                .i_new_id   (i_req.train_id),
                .i_new_time (w_new_time),
                .o_stat     (w_stat[gq]),
                .o_head_id  (w_head_id[gq]),
                .o_head_time(w_head_time[gq])
            );
            assign w_ne[gq] = w_stat[gq].nonempty;
        end
    endgenerate

    // grant choice from the registered state and the queue heads
    always_comb begin
        // preferred direction before any finish
        w_first_any = w_ne[{r_first_dir, 1'b0}] || w_ne[{r_first_dir, 1'b1}];
        w_first_q   = w_ne[{r_first_dir, 1'b0}] ? {r_first_dir, 1'b0}
                                                 : {r_first_dir, 1'b1};
        // opposite direction once the streak limit is reached
        w_opp     = ~r_last;
        w_opp_any = w_ne[{w_opp, 1'b0}] || w_ne[{w_opp, 1'b1}];
        w_opp_q   = w_ne[{w_opp, 1'b0}] ? {w_opp, 1'b0} : {w_opp, 1'b1};

        // earliest head within a class, lower id on a time tie, west on a full tie
        w_hi_e_first = (w_head_time[Q_EH] < w_head_time[Q_WH]) ||
                       ((w_head_time[Q_EH] == w_head_time[Q_WH]) &&
                        (w_head_id[Q_EH] < w_head_id[Q_WH]));
        w_lo_e_first = (w_head_time[Q_EL] < w_head_time[Q_WL]) ||
                       ((w_head_time[Q_EL] == w_head_time[Q_WL]) &&
                        (w_head_id[Q_EL] < w_head_id[Q_WL]));

        if (w_ne[Q_EH] && w_ne[Q_WH]) begin
            w_hi_q = w_hi_e_first ? Q_EH : Q_WH;
        end else begin
            w_hi_q = w_ne[Q_EH] ? Q_EH : Q_WH;
        end
        if (w_ne[Q_EL] && w_ne[Q_WL]) begin
            w_lo_q = w_lo_e_first ? Q_EL : Q_WL;
        end else begin
            w_lo_q = w_ne[Q_EL] ? Q_EL : Q_WL;
        end

        if (!r_ever && w_first_any) begin
            w_g_q = w_first_q;
        end else if ((r_streak >= r_streak_limit) && w_opp_any) begin
            w_g_q = w_opp_q;
        end else if (w_ne[Q_EH] || w_ne[Q_WH]) begin
            w_g_q = w_hi_q;
        end else begin
            w_g_q = w_lo_q;
        end

        w_g_valid = !r_busy && (w_ne != '0);
    end

    // sequencer: update cycle, then grant cycle
    always_comb begin
        n_state       = r_state;
        n_busy        = r_busy;
        n_gdir        = r_gdir;
        n_streak      = r_streak;
        n_last        = r_last;
        n_ever        = r_ever;
        n_out_valid   = r_out_valid;
        n_status      = r_status;
        n_grant_valid = r_grant_valid;
        n_grant_id    = r_grant_id;
        n_grant_dir   = r_grant_dir;
        n_out_status  = r_out_status;
        for (int q = 0; q < NUM_Q; q++) begin
            w_ctrl[q] = '0;
        end
        i_req.ready = (r_state == S_IDLE);

        // output register drains when taken
        if (r_out_valid && o_grant.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state  = S_GRANT;
                    n_status = ST_OK;
                    if (i_req.req_type == REQ_ARRIVE) begin
                        if (w_stat[w_q_in].full) begin
                            n_status = ST_DROPPED;
                        end else begin
                            w_ctrl[w_q_in].ins = 1'b1;
                        end
                    end else if (!r_busy) begin
                        n_status = ST_IDLE_FINISH;
                    end else begin
                        n_busy = 1'b0;
                        n_ever = 1'b1;
                        if (r_gdir == r_last) begin
                            // saturating same-direction streak
                            if ((r_streak < r_streak_limit) && (r_streak != STREAK_MAX)) begin
                                n_streak = r_streak + 2'd1;
                            end
                        end else begin
                            n_last   = r_gdir;
                            n_streak = 2'd1;
                        end
                    end
                end
            end
            S_GRANT: begin
                // wait for a free output register
                if (!r_out_valid || o_grant.ready) begin
                    n_state       = S_IDLE;
                    n_out_valid   = 1'b1;
                    n_out_status  = r_status;
                    n_grant_valid = w_g_valid;
                    n_grant_id    = '0;
                    n_grant_dir   = 1'b0;
                    if (w_g_valid) begin
                        n_grant_id        = w_head_id[w_g_q];
                        n_grant_dir       = w_g_q[1];
                        w_ctrl[w_g_q].pop = 1'b1;
                        n_busy            = 1'b1;
                        n_gdir            = w_g_q[1];
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= 1'b0;
            r_gdir      <= 1'b0;
            r_streak    <= 2'd0;
            r_last      <= 1'b0;
            r_ever      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_gdir      <= n_gdir;
            r_streak    <= n_streak;
            r_last      <= n_last;
            r_ever      <= n_ever;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status      <= n_status;
        r_grant_valid <= n_grant_valid;
        r_grant_id    <= n_grant_id;
        r_grant_dir   <= n_grant_dir;
        r_out_status  <= n_out_status;
    end

    assign o_grant.valid       = r_out_valid;
    assign o_grant.grant_valid = r_grant_valid;
    assign o_grant.grant_id    = r_grant_id;
    assign o_grant.grant_dir   = r_grant_dir;
    assign o_grant.status      = r_out_status;

endmodule

// ----- hdl/dbpd_checker.sv -----
`include "assert_macros.svh"

module dbpd_checker import dbpd_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_req_valid,
    input logic            i_req_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input logic            i_grant_valid,
    input logic [ID_W-1:0] i_grant_id,
    input logic            i_grant_dir,
    input logic [1:0]      i_status
);

    // one event in flight: no accept in the cycle after an accept
    `ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready, "event accepted back to back")

    // a stalled result holds
    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_grant_valid) && $stable(i_grant_id) && $stable(i_grant_dir) && $stable(i_status), "stalled result changed")

    // no grant means zero id and direction
    `ASSERT_SAME(a_no_grant_zero, i_clk, i_rst_n, i_out_valid && !i_grant_valid, (i_grant_id == '0) && !i_grant_dir, "idle grant fields not zero")

    // a finish while idle implies every queue was empty, so no grant
    `ASSERT_SAME(a_idle_finish_no_grant, i_clk, i_rst_n, i_out_valid && (i_status == ST_IDLE_FINISH), !i_grant_valid, "grant after finish while idle")

endmodule

bind direction_balanced_priority_dispatcher dbpd_checker u_dbpd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_out_valid  (o_grant.valid),
    .i_out_ready  (o_grant.ready),
    .i_grant_valid(o_grant.grant_valid),
    .i_grant_id   (o_grant.grant_id),
    .i_grant_dir  (o_grant.grant_dir),
    .i_status     (o_grant.status)
);

// ----- tb/sv/tb_direction_balanced_priority_dispatcher.sv -----
module tb_direction_balanced_priority_dispatcher;
    import dbpd_pkg::*;

    // block build used here
    localparam int Q_DEPTH = 16;
    localparam int T_WIDTH = 32;

    // run shape
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 320;
    localparam int HOLD_AT     = 450;   // transactions taken before the long receiver stall
    localparam int HOLD_LEN    = 150;
    localparam int STALL_LIMIT = 2000;  // cycles with no transaction on either side

    // register settings and idling per phase
    localparam logic [1:0] LIMIT_PLAN [PHASES] = '{2'd1, 2'd3, 2'd0, 2'd2, 2'd3};
    localparam logic       DIR_PLAN   [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    localparam int         SRC_IDLE   [PHASES] = '{7, 0, 7, 0, 7};
    localparam int         SNK_IDLE   [PHASES] = '{7, 0, 0, 7, 7};

    typedef struct packed {
        t_req_type            kind;
        logic [ID_W-1:0]      id;
        logic                 dir;
        logic                 high;
        logic [IN_TIME_W-1:0] ready_at;
    } t_train;

    typedef struct packed {
        logic            granted;
        logic [ID_W-1:0] id;
        logic            dir;
        t_status         status;
    } t_grant;

    typedef enum int {
        BURST_MIXED,
        BURST_FLOOD,
        BURST_DRAIN,
        BURST_RUN
    } t_burst_kind;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    dbpd_req_if   req_bus ();
    dbpd_grant_if grant_bus ();

    direction_balanced_priority_dispatcher #(
        .QUEUE_DEPTH(Q_DEPTH),
        .TIME_WIDTH (T_WIDTH)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .i_req  (req_bus),
        .o_grant(grant_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // dispatcher prediction: four sorted waiting lines plus streak history
    // ------------------------------------------------------------------
    logic [ID_W-1:0]    line_id  [NUM_Q][Q_DEPTH];
    logic [T_WIDTH-1:0] line_t   [NUM_Q][Q_DEPTH];
    int                 line_cnt [NUM_Q] = '{0, 0, 0, 0};
    logic               busy         = 1'b0;
    logic               held_dir     = 1'b0;
    logic [1:0]         streak       = 2'd0;
    logic               streak_dir   = 1'b0;
    logic               any_finished = 1'b0;
    logic [1:0]         cfg_streak_limit = STREAK_LIMIT_RST;
    logic               cfg_first_dir    = FIRST_DIR_RST;

    // line number is {direction, low class}
    function automatic logic [1:0] line_of(input logic dir, input logic high);
        return {dir, ~high};
    endfunction

    function automatic logic ahead_of(input logic [ID_W-1:0] ida, input logic [T_WIDTH-1:0] ta,
                                      input logic [ID_W-1:0] idb, input logic [T_WIDTH-1:0] tb);
        if (ta != tb) return ta < tb;
        return ida < idb;
    endfunction

    // sorted insert after all equal entries, refused when the line is full
    function automatic logic park_train(input logic [1:0] q, input logic [ID_W-1:0] id,
                                        input logic [T_WIDTH-1:0] t);
        int p;
        p = 0;
        if (line_cnt[q] >= Q_DEPTH) return 1'b0;
        while (p < line_cnt[q] && !ahead_of(id, t, line_id[q][p], line_t[q][p])) p++;
        for (int k = line_cnt[q]; k > p; k--) begin
            line_id[q][k] = line_id[q][k-1];
            line_t[q][k]  = line_t[q][k-1];
        end
        line_id[q][p] = id;
        line_t[q][p]  = t;
        line_cnt[q]++;
        return 1'b1;
    endfunction

    function automatic logic [ID_W-1:0] take_head(input logic [1:0] q);
        logic [ID_W-1:0] id;
        id = line_id[q][0];
        for (int k = 1; k < line_cnt[q]; k++) begin
            line_id[q][k-1] = line_id[q][k];
            line_t[q][k-1]  = line_t[q][k];
        end
        line_cnt[q]--;
        return id;
    endfunction

    // within one direction the high class goes first
    function automatic int side_head(input logic dir);
        if (line_cnt[line_of(dir, 1'b1)] != 0) return line_of(dir, 1'b1);
        if (line_cnt[line_of(dir, 1'b0)] != 0) return line_of(dir, 1'b0);
        return -1;
    endfunction

    // within one class the earlier head wins, west on a full tie
    function automatic int class_head(input logic high);
        logic [1:0] e;
        logic [1:0] w;
        e = line_of(1'b0, high);
        w = line_of(1'b1, high);
        if (line_cnt[e] != 0 && line_cnt[w] != 0)
            return ahead_of(line_id[e][0], line_t[e][0], line_id[w][0], line_t[w][0]) ? e : w;
        if (line_cnt[e] != 0) return e;
        if (line_cnt[w] != 0) return w;
        return -1;
    endfunction

    function automatic int next_line();
        int q;
        if (!any_finished) begin
            q = side_head(cfg_first_dir);
            if (q >= 0) return q;
        end
        if (streak >= cfg_streak_limit) begin
            q = side_head(~streak_dir);
            if (q >= 0) return q;
        end
        q = class_head(1'b1);
        if (q >= 0) return q;
        return class_head(1'b0);
    endfunction

    function automatic t_grant dispatch_step(input t_train tr);
        t_grant g;
        int     q;
        g = '{granted: 1'b0, id: '0, dir: 1'b0, status: ST_OK};
        if (tr.kind == REQ_ARRIVE) begin
            if (!park_train(line_of(tr.dir, tr.high), tr.id, tr.ready_at[T_WIDTH-1:0]))
                g.status = ST_DROPPED;
        end else if (!busy) begin
            g.status = ST_IDLE_FINISH;
        end else begin
            busy         = 1'b0;
            any_finished = 1'b1;
            // same direction extends the streak up to the limit, else a new streak
            if (held_dir == streak_dir) begin
                if (streak < cfg_streak_limit && streak < STREAK_MAX) streak = streak + 2'd1;
            end else begin
                streak_dir = held_dir;
                streak     = 2'd1;
            end
        end
        if (!busy) begin
            q = next_line();
            if (q >= 0) begin
                g.granted = 1'b1;
                g.dir     = q[1];
                g.id      = take_head(q[1:0]);
                busy      = 1'b1;
                held_dir  = q[1];
            end
        end
        return g;
    endfunction

    // ------------------------------------------------------------------
    // stimulus store, driver, receiver and checking
    // ------------------------------------------------------------------
    t_train trains_to_send [$];
    t_grant grants_due [$];
    int     items_queued   = 0;
    int     grants_seen    = 0;
    int     events_taken   = 0;
    int     mismatches     = 0;
    int     cfg_errors     = 0;
    int     predicted_wins = 0;
    int     predicted_drop = 0;
    int     predicted_idle = 0;
    int     src_idle_max   = 0;
    int     snk_idle_max   = 0;
    int     src_wait       = 0;
    int     snk_wait       = 0;
    int     hold_left      = 0;
    int     stall_cycles   = 0;
    logic   snk_hold       = 1'b0;
    logic   hold_done      = 1'b0;

    // driver: one transaction offered at a time, random gap after each
    always @(posedge i_clk) begin : feed
        t_train nxt;
        logic   offering;
        if (!i_rst_n) begin
            req_bus.valid      <= 1'b0;
            req_bus.req_type   <= REQ_ARRIVE;
            req_bus.train_id   <= '0;
            req_bus.train_dir  <= 1'b0;
            req_bus.hi_class   <= 1'b0;
            req_bus.ready_time <= '0;
            src_wait = 0;
        end else begin
            offering = req_bus.valid && !req_bus.ready;
            if (req_bus.valid && req_bus.ready) src_wait = $urandom_range(0, src_idle_max);
            if (!offering) begin
                if (src_wait == 0 && trains_to_send.size() != 0) begin
                    nxt = trains_to_send.pop_front();
                    req_bus.valid      <= 1'b1;
                    req_bus.req_type   <= nxt.kind;
                    req_bus.train_id   <= nxt.id;
                    req_bus.train_dir  <= nxt.dir;
                    req_bus.hi_class   <= nxt.high;
                    req_bus.ready_time <= nxt.ready_at;
                end else begin
                    if (src_wait != 0) src_wait--;
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stall after each grant transaction, forced low while held off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            grant_bus.ready <= 1'b0;
            snk_wait = 0;
        end else begin
            if (grant_bus.valid && grant_bus.ready) snk_wait = $urandom_range(0, snk_idle_max);
            if (snk_hold) begin
                grant_bus.ready <= 1'b0;
            end else if (snk_wait != 0) begin
                snk_wait--;
                grant_bus.ready <= 1'b0;
            end else begin
                grant_bus.ready <= 1'b1;
            end
        end
    end

    // one long hold-off so the output register and the input both back up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            snk_hold  <= 1'b0;
            hold_done <= 1'b0;
            hold_left <= 0;
        end else if (!hold_done && events_taken >= HOLD_AT) begin
            snk_hold  <= 1'b1;
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            if (hold_left == 1) snk_hold <= 1'b0;
        end
    end

    // check finished grants first, then predict the transaction taken at this edge
    always @(posedge i_clk) begin : check
        t_grant seen;
        t_grant due;
        if (i_rst_n) begin
            if (grant_bus.valid && grant_bus.ready) begin
                seen = '{granted: grant_bus.grant_valid, id: grant_bus.grant_id,
                         dir: grant_bus.grant_dir, status: t_status'(grant_bus.status)};
                grants_seen <= grants_seen + 1;
                if (grants_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected grant transaction valid=%0d id=%0d dir=%0d status=%0d",
                             $time, seen.granted, seen.id, seen.dir, seen.status);
                end else begin
                    due = grants_due.pop_front();
                    if (seen.granted !== due.granted || seen.id !== due.id ||
                        seen.dir !== due.dir || seen.status !== due.status) begin
                        mismatches++;
                        $display("%0t: grant mismatch expected valid=%0d id=%0d dir=%0d status=%0d",
                                 $time, due.granted, due.id, due.dir, due.status);
                        $display("%0t:                  actual valid=%0d id=%0d dir=%0d status=%0d",
                                 $time, seen.granted, seen.id, seen.dir, seen.status);
                    end
                end
            end
            if (req_bus.valid && req_bus.ready) begin
                due = dispatch_step('{kind: t_req_type'(req_bus.req_type),
                                      id: req_bus.train_id, dir: req_bus.train_dir,
                                      high: req_bus.hi_class, ready_at: req_bus.ready_time});
                grants_due.push_back(due);
                events_taken <= events_taken + 1;
                if (due.granted) predicted_wins++;
                if (due.status == ST_DROPPED) predicted_drop++;
                if (due.status == ST_IDLE_FINISH) predicted_idle++;
            end
        end
    end

    // watchdog on progress of either channel
    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (grant_bus.valid && grant_bus.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------
    function automatic t_train make_train(input t_req_type kind, input logic [ID_W-1:0] id,
                                          input logic dir, input logic high,
                                          input logic [IN_TIME_W-1:0] t);
        return '{kind: kind, id: id, dir: dir, high: high, ready_at: t};
    endfunction

    task automatic send(input t_train tr);
        trains_to_send.push_back(tr);
        items_queued++;
    endtask

    // every grant transaction back and nothing left in flight
    task automatic wait_quiet();
        wait (grants_seen == items_queued && grants_due.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    // write, then read back the same register
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] mask;
        mask = (idx == REG_STREAK_LIMIT) ? 32'd3 : 32'd1;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == REG_STREAK_LIMIT) cfg_streak_limit = value[1:0];
        else cfg_first_dir = value[0];
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if ((prdata & mask) !== (value & mask)) begin
            cfg_errors++;
            $display("%0t: register %s readback expected %0d, actual %0d",
                     $time, idx.name(), value & mask, prdata & mask);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // hand-picked events, run with streak limit 1
    task automatic queue_directed();
        // finish with nothing granted, all other fields at their top value
        send(make_train(REQ_FINISH, 6'd63, 1'b1, 1'b1, 32'hFFFF_FFFF));
        // first arrival is granted at once
        send(make_train(REQ_ARRIVE, 6'd63, 1'b0, 1'b0, 32'hFFFF_FFFF));
        // fill west high, time ties broken by id
        for (int k = 0; k < Q_DEPTH; k++)
            send(make_train(REQ_ARRIVE, 6'(15 - k), 1'b1, 1'b1, 32'(k / 4)));
        // west high full, this one is dropped
        send(make_train(REQ_ARRIVE, 6'd0, 1'b1, 1'b1, 32'd0));
        // exact tie with the west high head
        send(make_train(REQ_ARRIVE, 6'd12, 1'b0, 1'b1, 32'd0));
        send(make_train(REQ_ARRIVE, 6'd0, 1'b0, 1'b0, 32'd0));
        // finishes flip direction every time at limit 1
        repeat (5) send(make_train(REQ_FINISH, 6'd0, 1'b0, 1'b0, 32'd0));
    endtask

    // bursts: mixed traffic, one line flooded, draining, one-direction runs
    task automatic queue_random(input int count);
        int                   left;
        int                   len;
        int                   fin_pct;
        t_burst_kind          kind;
        logic                 fix_dir;
        logic                 fix_high;
        logic                 dir;
        logic                 high;
        logic [ID_W-1:0]      id;
        logic [IN_TIME_W-1:0] t;
        t_req_type            op;
        left = count;
        while (left > 0) begin
            case ($urandom_range(0, 5))
                0, 1:    kind = BURST_MIXED;
                2:       kind = BURST_FLOOD;
                3, 4:    kind = BURST_DRAIN;
                default: kind = BURST_RUN;
            endcase
            fix_dir  = 1'($urandom_range(0, 1));
            fix_high = 1'($urandom_range(0, 1));
            len      = (kind == BURST_FLOOD) ? $urandom_range(18, 20) : $urandom_range(8, 24);
            case (kind)
                BURST_MIXED: fin_pct = 45;
                BURST_FLOOD: fin_pct = 0;
                BURST_DRAIN: fin_pct = 85;
                default:     fin_pct = 50;
            endcase
            for (int k = 0; k < len && left > 0; k++) begin
                op   = ($urandom_range(0, 99) < fin_pct) ? REQ_FINISH : REQ_ARRIVE;
                dir  = (kind == BURST_FLOOD || kind == BURST_RUN) ? fix_dir
                                                                  : 1'($urandom_range(0, 1));
                high = (kind == BURST_FLOOD) ? fix_high : 1'($urandom_range(0, 1));
                id   = ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 3))
                                                   : ID_W'($urandom_range(0, 63));
                // narrow times make ties, wide and extreme times cover every bit
                case ($urandom_range(0, 3))
                    0:       t = $urandom_range(0, 7);
                    1:       t = $urandom;
                    2:       t = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                    default: t = 32'hFFFF_FFF8 | $urandom_range(0, 7);
                endcase
                send(make_train(op, id, dir, high, t));
                left--;
            end
        end
    endtask

    initial begin
        req_bus.valid      = 1'b0;
        req_bus.req_type   = REQ_ARRIVE;
        req_bus.train_id   = '0;
        req_bus.train_dir  = 1'b0;
        req_bus.hi_class   = 1'b0;
        req_bus.ready_time = '0;
        grant_bus.ready    = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_quiet();
            write_reg(REG_STREAK_LIMIT, 32'(LIMIT_PLAN[ph]));
            write_reg(REG_FIRST_DIR, 32'(DIR_PLAN[ph]));
            src_idle_max = SRC_IDLE[ph];
            snk_idle_max = SNK_IDLE[ph];
            if (ph == 0) queue_directed();
            queue_random(PHASE_ITEMS);
        end
        wait_quiet();
        repeat (8) @(posedge i_clk);

        $display("covered %0d events over %0d register settings, %0d of them granting",
                 events_taken, PHASES, predicted_wins);
        $display("%0d arrivals dropped on a full line, %0d finishes ignored while idle",
                 predicted_drop, predicted_idle);
        if (grants_due.size() != 0)
            $display("%0t: %0d grant transactions never arrived", $time, grants_due.size());
        if (mismatches == 0 && cfg_errors == 0 && grants_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
